// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the sorted-insert priority queue
// no dependencies

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } spq_status_t;

  // operation broadcast to every cell in the row
  typedef struct packed {
    logic                    ins;
    logic                    pop;
    logic signed [VAL_W-1:0] value;
  } spq_op_t;

endpackage

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
// one storage cell of the sorted row: holds one value, shifts up on insert, down on pop
// depends on spq_pkg

module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  spq_op_t                 op,
  input  logic                    occupied,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic                    left_greater,
  input  logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0] val,
  output logic signed [VAL_W-1:0] val_nxt,
  output logic                    greater
);

  logic signed [VAL_W-1:0] val_r;

  // empty cells act as plus infinity so a value not below any held one lands at the first free slot
  assign greater = !occupied || (val_r > op.value);

  always_comb begin
    val_nxt = val_r;
    if (op.ins && greater) begin
      val_nxt = left_greater ? left_val : op.value;
    end else if (op.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== design/sorted_insert_priority_queue_top.sv =====
`timescale 1ns / 1ps
// top level of the sorted-insert priority queue: row of cells, entry count, result register
// depends on spq_pkg and spq_cell
//
// Usage:
//   Raise start for one cycle with in_command (insert or pop) and in_value;
//   the command is taken at that edge when busy is low. busy never rises, so
//   a new command may be given in every cycle.
//   In the cycle after, out_valid is high for one cycle with the popped
//   value, the new front value (0 when empty), the new entry count and the
//   status. Throughput is 1 command per cycle: every cell
//   compares its value with the incoming one in parallel and shifts in the
//   same edge, so the whole row of CAPACITY cells updates at once.
//   An insert into a full queue and a pop from an empty one change nothing
//   and are flagged in out_status.
//   Reset (rst_n low, synchronous) empties the queue and clears out_valid;
//   cell contents are not cleared, only cells below the count are read.
//   Results cannot be stalled: out_valid marks the only cycle of transfer.

module sorted_insert_priority_queue_top
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_command,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_popped_value,
  output logic signed [VAL_W-1:0] out_front_value,
  output logic [CNT_W-1:0]        out_entry_total,
  output logic [1:0]              out_status
);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_popped_value_r, out_popped_value_nxt;
  logic signed [VAL_W-1:0] out_front_value_r, out_front_value_nxt;
  logic [CNT_W-1:0]        out_entry_total_r;
  spq_status_t             out_status_r, out_status_nxt;

  logic                    take;
  logic                    is_full, is_empty;
  spq_op_t                 op;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic signed [VAL_W-1:0] cell_nxt [CAPACITY];
  logic                    cell_gt  [CAPACITY];

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign op.ins   = take && (in_command == CMD_INSERT) && !is_full;
  assign op.pop   = take && (in_command == CMD_POP) && !is_empty;
  assign op.value = in_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] lv, rv;
    logic                    lg;
    if (i == 0) begin : g_head
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .op           (op),
      .occupied     (CNT_W'(i) < count_r),
      .left_val     (lv),
      .left_greater (lg),
      .right_val    (rv),
      .val          (cell_val[i]),
      .val_nxt      (cell_nxt[i]),
      .greater      (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt            = count_r;
    out_popped_value_nxt = '0;
    out_status_nxt       = STAT_OK;
    if (op.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop) begin
      count_nxt            = count_r - CNT_W'(1);
      out_popped_value_nxt = cell_val[0];
    end
    if (take && (in_command == CMD_INSERT) && is_full) begin
      out_status_nxt = STAT_FULL;
    end else if (take && (in_command == CMD_POP) && is_empty) begin
      out_status_nxt = STAT_EMPTY;
    end
    out_front_value_nxt = (count_nxt != '0) ? cell_nxt[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    out_popped_value_r <= out_popped_value_nxt;
    out_front_value_r  <= out_front_value_nxt;
    out_entry_total_r  <= count_nxt;
    out_status_r       <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_value_r;
  assign out_front_value  = out_front_value_r;
  assign out_entry_total  = out_entry_total_r;
  assign out_status       = out_status_r;

  // every accepted command gives its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("no result after accepted command");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_EMPTY)) |->
      (out_entry_total == '0) && (out_popped_value == '0) && (out_front_value == '0))
    else $error("empty pop result inconsistent");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_entry_total == CNT_W'(CAPACITY)))
    else $error("rejected insert with free cells");

endmodule

// ===== bench/sorted_insert_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for sorted_insert_priority_queue_top: directed corner cases, then
// random insert/pop traffic under varying sender gaps, checked against a sorted-queue predictor
// depends on spq_pkg and the design files of the priority queue

module sorted_insert_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [VAL_W-1:0] popped;
    logic signed [VAL_W-1:0] front;
    logic [CNT_W-1:0]        total;
    spq_status_t             status;
  } queue_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_command;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_popped_value;
  logic signed [VAL_W-1:0] out_front_value;
  logic [CNT_W-1:0]        out_entry_total;
  logic [1:0]              out_status;

  // predictor state: values held in ascending order
  logic signed [VAL_W-1:0] held_values[$];
  queue_result_t           awaited_results[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned results_checked;
  int unsigned insert_total;
  int unsigned pop_total;
  int unsigned full_rejects;
  int unsigned empty_pops;
  int unsigned peak_depth;
  bit          filling;

  sorted_insert_priority_queue_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_entry_total  (out_entry_total),
    .out_status       (out_status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic queue_result_t predict_queue_step(input logic cmd,
                                                       input logic signed [VAL_W-1:0] v);
    queue_result_t r;
    int            pos;
    r.popped = '0;
    r.status = STAT_OK;
    if (cmd == CMD_INSERT) begin
      insert_total++;
      if (held_values.size() >= CAPACITY) begin
        r.status = STAT_FULL;
        full_rejects++;
      end else begin
        // new value goes after any equal ones
        pos = 0;
        while (pos < held_values.size() && !(held_values[pos] > v))
          pos++;
        held_values.insert(pos, v);
      end
    end else begin
      pop_total++;
      if (held_values.size() == 0) begin
        r.status = STAT_EMPTY;
        empty_pops++;
      end else begin
        r.popped = held_values.pop_front();
      end
    end
    r.front = (held_values.size() > 0) ? held_values[0] : '0;
    r.total = CNT_W'(held_values.size());
    if (held_values.size() > peak_depth)
      peak_depth = held_values.size();
    return r;
  endfunction

  // result channel cannot be held off, so every strobe is a transfer
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result transfer with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_popped_value !== want.popped)
          report_mismatch($sformatf("popped value %0d, want %0d", out_popped_value, want.popped));
        if (out_front_value !== want.front)
          report_mismatch($sformatf("front value %0d, want %0d", out_front_value, want.front));
        if (out_entry_total !== want.total)
          report_mismatch($sformatf("entry total %0d, want %0d", out_entry_total, want.total));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
      end
    end
  end

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic issue_command(input logic cmd, input logic signed [VAL_W-1:0] v);
    @(negedge clk);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= v;
    do
      @(posedge clk);
    while (busy !== 1'b0);
    awaited_results.push_back(predict_queue_step(cmd, v));
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // fill towards full, then drain towards empty, with some traffic against the trend
  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    logic cmd;
    for (int unsigned k = 0; k < count; k++) begin
      while ($urandom_range(99) < idle_pct)
        idle_cycle();
      if (held_values.size() >= CAPACITY)
        filling = 1'b0;
      else if (held_values.size() == 0)
        filling = 1'b1;
      else if ($urandom_range(49) == 0)
        filling = ~filling;
      if ($urandom_range(99) < 80)
        cmd = filling ? CMD_INSERT : CMD_POP;
      else
        cmd = filling ? CMD_POP : CMD_INSERT;
      issue_command(cmd, pick_value());
    end
  endtask

  task automatic test_empty_pop();
    issue_command(CMD_POP, 32'sh1234_5678);
  endtask

  task automatic test_fill_extremes();
    logic signed [VAL_W-1:0] fill_set [16] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 0, -1, 32'sh7FFF_FFFF,
      32'sh8000_0000, 5, -5, 5, 100, -100, 32'sh4000_0000, 32'shC000_0000};
    foreach (fill_set[i])
      issue_command(CMD_INSERT, fill_set[i]);
  endtask

  task automatic test_full_reject();
    issue_command(CMD_INSERT, 32'sh8000_0000);
  endtask

  task automatic test_pop_and_refill();
    issue_command(CMD_POP, 0);
    issue_command(CMD_POP, -1);
    issue_command(CMD_INSERT, 32'shFFFF_FFFE);
  endtask

  task automatic test_random_back_to_back();
    run_random(350, 0);
  endtask

  task automatic test_random_sparse_sender();
    run_random(300, 88);
  endtask

  task automatic test_random_light_idle();
    run_random(300, 10);
  endtask

  task automatic test_drain_pause();
    run_random(100, 0);
    do
      idle_cycle();
    while (awaited_results.size() != 0);
    run_random(100, 0);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_INSERT;
    in_value        = '0;
    error_count     = 0;
    cycle_count     = 0;
    results_checked = 0;
    insert_total    = 0;
    pop_total       = 0;
    full_rejects    = 0;
    empty_pops      = 0;
    peak_depth      = 0;
    filling         = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pop();
    test_fill_extremes();
    test_full_reject();
    test_pop_and_refill();
    test_random_back_to_back();
    test_random_sparse_sender();
    test_random_light_idle();
    test_drain_pause();

    idle_cycle();
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d inserts and %0d pops, %0d results checked, peak depth %0d",
             insert_total, pop_total, results_checked, peak_depth);
    $display("inserts refused on a full queue: %0d, pops on an empty queue: %0d",
             full_rejects, empty_pops);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_insert_priority_queue_top.sv
bench/sorted_insert_priority_queue_top_tb.sv
